// ----- src/ppbp_pkg.sv -----
// ppbp_pkg: shared constants and types for pick_point_between_pair.
// No dependencies.
package ppbp_pkg;

	localparam int CoordW = 16;
	localparam int IdW = 10;
	localparam int IdxW = 10;
	localparam int ScoreW = 24;
	// squared distances: 2 * 16-bit diff squared, times 2^8 -> 41 bits, held in RadW
	localparam int RadW = 44;
	localparam int RootW = RadW / 2;
	localparam int DivW = 48;
	localparam int DivCntW = 6;
	localparam int RootCntW = 5;
	localparam logic [IdxW-1:0] IcReset = '1;
	localparam logic [ScoreW-1:0] ScoreMax = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_TEST,
		ST_RT_AB,
		ST_RT_AC,
		ST_RT_BC,
		ST_RT_MID,
		ST_DIV,
		ST_SCORE,
		ST_OUT
	} ppbp_state_t;

	typedef struct packed {
		logic load;      // latch input item
		logic sq_calc;   // compute squares and cross product
		logic rt_start;  // start a root on selected operand
		logic [1:0] rt_sel;
		logic div_start;
		logic score;     // form score, update best
		logic emit;      // load output register and clear run
	} ppbp_cmd_t;

	typedef struct packed {
		logic reject;    // A == B or outside 0.6 window
		logic rt_done;
		logic div_done;
		logic is_last;
	} ppbp_sts_t;

	localparam logic [1:0] RtAb = 2'd0;
	localparam logic [1:0] RtAc = 2'd1;
	localparam logic [1:0] RtBc = 2'd2;
	localparam logic [1:0] RtMid = 2'd3;

endpackage

// ----- src/ppbp_ctrl.sv -----
// ppbp_ctrl: sequencer for one candidate item.
// Depends on ppbp_pkg.
module ppbp_ctrl import ppbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_busy,
	input  ppbp_sts_t sts,
	output logic in_ready,
	output ppbp_cmd_t cmd
);
	ppbp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SQ;
			ST_SQ: state_d = ST_TEST;
			ST_TEST: state_d = sts.reject ? (sts.is_last ? ST_OUT : ST_IDLE) : ST_RT_AB;
			ST_RT_AB: if (sts.rt_done) state_d = ST_RT_AC;
			ST_RT_AC: if (sts.rt_done) state_d = ST_RT_BC;
			ST_RT_BC: if (sts.rt_done) state_d = ST_RT_MID;
			ST_RT_MID: if (sts.rt_done) state_d = ST_DIV;
			ST_DIV: if (sts.div_done) state_d = ST_SCORE;
			ST_SCORE: state_d = sts.is_last ? ST_OUT : ST_IDLE;
			ST_OUT: if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SQ: cmd.sq_calc = 1'b1;
			ST_TEST: begin
				cmd.rt_start = !sts.reject;
				cmd.rt_sel = RtAb;
			end
			ST_RT_AB: begin
				cmd.rt_start = sts.rt_done;
				cmd.rt_sel = RtAc;
			end
			ST_RT_AC: begin
				cmd.rt_start = sts.rt_done;
				cmd.rt_sel = RtBc;
			end
			ST_RT_BC: begin
				cmd.rt_start = sts.rt_done;
				cmd.rt_sel = RtMid;
			end
			ST_RT_MID: cmd.div_start = sts.rt_done;
			ST_SCORE: cmd.score = 1'b1;
			ST_OUT: cmd.emit = !out_busy;
			default: cmd = '0;
		endcase
	end
endmodule

// ----- src/ppbp_dp.sv -----
// ppbp_dp: datapath with squares, shared bit-serial square root, divider,
// best-candidate tracking and output register. Depends on ppbp_pkg.
module ppbp_dp import ppbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ppbp_cmd_t cmd,
	output ppbp_sts_t sts,
	input  logic [6*CoordW+IdW+IdxW:0] in_data,
	input  logic [IdxW-1:0] ic_count,
	input  logic out_ready,
	output logic out_valid,
	output logic out_busy,
	output logic found,
	output logic [IdW-1:0] sel_id,
	output logic [CoordW-1:0] sel_x,
	output logic [CoordW-1:0] sel_y,
	output logic [IdxW-1:0] label
);
	logic [CoordW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [IdW-1:0] id_q;
	logic [IdxW-1:0] light_q;
	logic last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ax_q <= in_data[0*CoordW +: CoordW];
			ay_q <= in_data[1*CoordW +: CoordW];
			bx_q <= in_data[2*CoordW +: CoordW];
			by_q <= in_data[3*CoordW +: CoordW];
			cx_q <= in_data[4*CoordW +: CoordW];
			cy_q <= in_data[5*CoordW +: CoordW];
			id_q <= in_data[6*CoordW +: IdW];
			light_q <= in_data[6*CoordW+IdW +: IdxW];
			last_q <= in_data[6*CoordW+IdW+IdxW];
		end
	end

	// squares, one stage
	logic signed [CoordW:0] dabx, daby, dacx, dacy, dbcx, dbcy;
	logic signed [CoordW+2:0] dmx, dmy;
	logic [34:0] ab2_q, ac2_q, bc2_q;
	logic [37:0] mid2_q;
	logic signed [34:0] cross_q;
	logic [33:0] p1, p2;

	assign dabx = $signed({1'b0, bx_q}) - $signed({1'b0, ax_q});
	assign daby = $signed({1'b0, by_q}) - $signed({1'b0, ay_q});
	assign dacx = $signed({1'b0, cx_q}) - $signed({1'b0, ax_q});
	assign dacy = $signed({1'b0, cy_q}) - $signed({1'b0, ay_q});
	assign dbcx = $signed({1'b0, cx_q}) - $signed({1'b0, bx_q});
	assign dbcy = $signed({1'b0, cy_q}) - $signed({1'b0, by_q});
	assign dmx = $signed({2'b0, cx_q, 1'b0}) - $signed({3'b0, ax_q}) - $signed({3'b0, bx_q});
	assign dmy = $signed({2'b0, cy_q, 1'b0}) - $signed({3'b0, ay_q}) - $signed({3'b0, by_q});
	assign p1 = 34'($signed(dacy) * $signed(dabx));
	assign p2 = 34'($signed(dacx) * $signed(daby));

	function automatic logic [33:0] sqr17(input logic signed [CoordW:0] d);
		logic [CoordW:0] m;
		m = d[CoordW] ? 17'(-d) : 17'(d);
		return 34'(m) * 34'(m);
	endfunction

	function automatic logic [37:0] sqr19(input logic signed [CoordW+2:0] d);
		logic [CoordW+2:0] m;
		m = d[CoordW+2] ? 19'(-d) : 19'(d);
		return 38'(m) * 38'(m);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.sq_calc) begin
			ab2_q <= 35'(sqr17(dabx)) + 35'(sqr17(daby));
			ac2_q <= 35'(sqr17(dacx)) + 35'(sqr17(dacy));
			bc2_q <= 35'(sqr17(dbcx)) + 35'(sqr17(dbcy));
			mid2_q <= sqr19(dmx) + sqr19(dmy);
			cross_q <= $signed(35'($signed(p1))) - $signed(35'($signed(p2)));
		end
	end

	logic [39:0] ab9, ac25, bc25;
	assign ab9 = 40'(ab2_q) * 40'd9;
	assign ac25 = 40'(ac2_q) * 40'd25;
	assign bc25 = 40'(bc2_q) * 40'd25;
	assign sts.reject = (ab2_q == '0) || (ac25 > ab9) || (bc25 > ab9);
	assign sts.is_last = last_q;

	// shared square root, one result bit a cycle
	logic [RadW-1:0] rt_rem_q, rt_val_q;
	logic [RootW-1:0] rt_res_q;
	logic [RootCntW-1:0] rt_cnt_q;
	logic rt_busy_q;
	logic [RadW-1:0] rt_in;
	logic [RootW+1:0] rt_trial, rt_top;
	logic [RootW-1:0] ab_q, ac_q, bc_q, mid_q;
	logic [1:0] rt_sel_q;

	always_comb begin
		case (cmd.rt_sel)
			RtAb: rt_in = RadW'({ab2_q, 8'b0});
			RtAc: rt_in = RadW'({ac2_q, 8'b0});
			RtBc: rt_in = RadW'({bc2_q, 8'b0});
			RtMid: rt_in = RadW'({mid2_q, 6'b0});
			default: rt_in = '0;
		endcase
	end

	assign rt_top = {rt_rem_q[RootW-1:0], rt_val_q[RadW-1 -: 2]};
	assign rt_trial = {rt_res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_busy_q <= 1'b0;
			rt_cnt_q <= '0;
		end else if (cmd.rt_start) begin
			rt_busy_q <= 1'b1;
			rt_cnt_q <= '0;
		end else if (rt_busy_q) begin
			rt_cnt_q <= rt_cnt_q + 1'b1;
			if (rt_cnt_q == RootCntW'(RootW - 1)) rt_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rt_start) begin
			rt_val_q <= rt_in;
			rt_rem_q <= '0;
			rt_res_q <= '0;
			rt_sel_q <= cmd.rt_sel;
		end else if (rt_busy_q) begin
			rt_val_q <= rt_val_q << 2;
			if (rt_top >= rt_trial) begin
				rt_rem_q <= RadW'(rt_top - rt_trial);
				rt_res_q <= {rt_res_q[RootW-2:0], 1'b1};
			end else begin
				rt_rem_q <= RadW'(rt_top);
				rt_res_q <= {rt_res_q[RootW-2:0], 1'b0};
			end
		end
	end

	logic rt_busy_d1_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_busy_d1_q <= 1'b0;
		else rt_busy_d1_q <= rt_busy_q;
	end
	assign sts.rt_done = rt_busy_d1_q && !rt_busy_q;

	always_ff @(posedge clk) begin
		if (sts.rt_done) begin
			case (rt_sel_q)
				RtAb: ab_q <= rt_res_q;
				RtAc: ac_q <= rt_res_q;
				RtBc: bc_q <= rt_res_q;
				RtMid: mid_q <= rt_res_q;
				default: ab_q <= rt_res_q;
			endcase
		end
	end

	// restoring divider: |cross| * 256 / ab
	logic [DivW-1:0] dv_num_q, dv_quo_q;
	logic [RootW:0] dv_rem_q;
	logic [DivCntW-1:0] dv_cnt_q;
	logic dv_busy_q, dv_busy_d1_q;
	logic [RootW+1:0] dv_try;
	logic [34:0] across;

	assign across = cross_q[34] ? 35'(-cross_q) : 35'(cross_q);
	assign dv_try = {dv_rem_q, dv_num_q[DivW-1]} - {1'b0, 1'b0, ab_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_busy_d1_q <= 1'b0;
			dv_cnt_q <= '0;
		end else begin
			dv_busy_d1_q <= dv_busy_q;
			if (cmd.div_start) begin
				dv_busy_q <= 1'b1;
				dv_cnt_q <= '0;
			end else if (dv_busy_q) begin
				dv_cnt_q <= dv_cnt_q + 1'b1;
				if (dv_cnt_q == DivCntW'(DivW - 1)) dv_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_num_q <= DivW'({across, 8'b0});
			dv_rem_q <= '0;
			dv_quo_q <= '0;
		end else if (dv_busy_q) begin
			dv_num_q <= dv_num_q << 1;
			if (!dv_try[RootW+1]) begin
				dv_rem_q <= dv_try[RootW:0];
				dv_quo_q <= {dv_quo_q[DivW-2:0], 1'b1};
			end else begin
				dv_rem_q <= {dv_rem_q[RootW-1:0], dv_num_q[DivW-1]};
				dv_quo_q <= {dv_quo_q[DivW-2:0], 1'b0};
			end
		end
	end
	assign sts.div_done = dv_busy_d1_q && !dv_busy_q;

	// score and best tracking
	logic [RootW-1:0] d1, d2;
	logic [DivW+3:0] sum;
	logic [ScoreW-1:0] score;
	assign d1 = (ac_q > ab_q) ? ac_q - ab_q : ab_q - ac_q;
	assign d2 = (bc_q > ab_q) ? bc_q - ab_q : ab_q - bc_q;
	assign sum = (DivW+4)'(d1) + (DivW+4)'(d2) + (DivW+4)'(mid_q)
		+ (DivW+4)'({dv_quo_q, 1'b0});
	assign score = (sum > (DivW+4)'(ScoreMax)) ? ScoreMax : sum[ScoreW-1:0];

	logic [ScoreW-1:0] best_score_q;
	logic [IdW-1:0] best_id_q;
	logic [CoordW-1:0] best_x_q, best_y_q;
	logic have_best_q;
	logic take;
	assign take = cmd.score && (!have_best_q || score < best_score_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			best_score_q <= ScoreMax;
			best_id_q <= '0;
			best_x_q <= '0;
			best_y_q <= '0;
		end else if (cmd.emit) begin
			have_best_q <= 1'b0;
			best_score_q <= ScoreMax;
			best_id_q <= '0;
			best_x_q <= '0;
			best_y_q <= '0;
		end else if (take) begin
			have_best_q <= 1'b1;
			best_score_q <= score;
			best_id_q <= id_q;
			best_x_q <= cx_q;
			best_y_q <= cy_q;
		end
	end

	// output register
	logic ok;
	assign ok = have_best_q && (light_q <= ic_count);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.emit) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			found <= ok;
			sel_id <= ok ? best_id_q : '0;
			sel_x <= ok ? best_x_q : '0;
			sel_y <= ok ? best_y_q : '0;
			label <= ok ? light_q : '0;
		end
	end
	assign out_busy = out_valid && !out_ready;
endmodule

// ----- src/pick_point_between_pair.sv -----
// pick_point_between_pair: top level joining controller, datapath and
// configuration register. Depends on ppbp_pkg, ppbp_ctrl, ppbp_dp.
//
// Usage: a run of candidate requests enters on s_axis; each carries anchors
// A and B, candidate C, its id and the light index, tlast marks the last one.
// Candidates within 0.6*|AB| of both anchors get a score from three distances
// and a line distance; the least score wins, the earlier on ties.
// On the tlast request one result goes out on m_axis: found, id, x, y, label.
// Steps: a rejected candidate passes the load, square and test steps; a scored
// one then runs four roots on the shared bit-serial square root (22 result
// bits each), the bit-serial divider and a score step; the last request of a
// run adds an output step to load the result. s_axis_tready is high only while
// the sequencer is idle.
// The result sits in an output register while the receiver stalls; the
// sequencer goes on with the next run and waits in its output step only
// when that run ends while the previous result is still pending.
// cfg_valid/cfg_ready write ic_count (always ready); write only when idle.
// Reset: ic_count returns to 1023, the run state clears, no result pending.
module pick_point_between_pair import ppbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [IdxW-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: ax, ay, bx, by, cx, cy, cand_id, light_index, pad (120 bits)
	input  logic [119:0] s_axis_tdata,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata: found, sel_id, sel_x, sel_y, label, pad (56 bits)
	output logic [55:0] m_axis_tdata
);
	logic [IdxW-1:0] ic_count_q;
	ppbp_cmd_t cmd;
	ppbp_sts_t sts;
	logic out_busy;
	logic found;
	logic [IdW-1:0] sel_id;
	logic [CoordW-1:0] sel_x, sel_y;
	logic [IdxW-1:0] label;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ic_count_q <= IcReset;
		else if (cfg_valid) ic_count_q <= cfg_data;
	end

	ppbp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.out_busy(out_busy), .sts(sts), .in_ready(s_axis_tready), .cmd(cmd)
	);

	ppbp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_data({s_axis_tlast, s_axis_tdata[6*CoordW+IdW+IdxW-1:0]}),
		.ic_count(ic_count_q), .out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid), .out_busy(out_busy), .found(found),
		.sel_id(sel_id), .sel_x(sel_x), .sel_y(sel_y), .label(label)
	);

	assign m_axis_tdata = {3'b0, label, sel_y, sel_x, sel_id, found};
endmodule

// ----- src/ppbp_checker.sv -----
// ppbp_checker: port-level assertions for pick_point_between_pair, bound in.
// Depends on ppbp_pkg.
module ppbp_checker import ppbp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tlast,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [55:0] m_axis_tdata
);
	// one request at a time: input closes right after a request is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input open after request");
	// a non-last request never raises a result next cycle
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> !$rose(m_axis_tvalid))
		else $error("result mid run");
	// not found means empty payload
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[52:1] == '0))
		else $error("payload not cleared");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped");
endmodule

bind pick_point_between_pair ppbp_checker u_ppbp_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
